// ===== rtl/core/pts_pkg.sv =====
package pts_pkg;

    // Operation codes
    localparam logic [2:0] OP_INIT       = 3'd0;
    localparam logic [2:0] OP_SCHEDULE   = 3'd1;
    localparam logic [2:0] OP_RESCHEDULE = 3'd2;
    localparam logic [2:0] OP_STOP       = 3'd3;
    localparam logic [2:0] OP_MANAGE     = 3'd4;

    // Slot states
    localparam logic [1:0] ST_STOPPED   = 2'd0;
    localparam logic [1:0] ST_SCHEDULED = 2'd1;
    localparam logic [1:0] ST_RUNNING   = 2'd3;

    // A due slot this late is pulled forward to now
    localparam logic [15:0] LATE_LIMIT = 16'd16484;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_PASS,
        S_WALK,
        S_INSSET,
        S_EMIT,
        S_ACK
    } ctl_state_t;

    typedef struct packed {
        logic load;
        logic setup_edit;
        logic step_pass;
        logic step_walk;
        logic setup_ins;
        logic emit;
        logic ack;
    } pts_cmd_t;

    typedef struct packed {
        logic is_manage;
        logic edit_ok;
        logic pass_done;
        logic walk_done;
        logic stk_empty;
        logic fired_empty;
        logic fired_last;
    } pts_sts_t;

    // True when (int16)(a - b) <= 0
    function automatic logic not_later(input logic [15:0] a, input logic [15:0] b);
        logic [15:0] d;
        d = a - b;
        return (d == 16'd0) || d[15];
    endfunction

endpackage

// ===== rtl/core/pts_dpath.sv =====
module pts_dpath import pts_pkg::*; #(
    parameter int NumTimers = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  pts_cmd_t    cmd,
    output pts_sts_t    sts,
    input  logic [2:0]  operation,
    input  logic [3:0]  timer_id,
    input  logic [15:0] ticks,
    input  logic [15:0] now,
    input  logic [7:0]  current_priority,
    input  logic [7:0]  new_priority,
    output logic        strobe,
    output logic [3:0]  fired_id,
    output logic        fired,
    output logic        last
);

    localparam int IdW  = $clog2(NumTimers);
    localparam int CntW = $clog2(NumTimers + 1);

    typedef logic [IdW-1:0]  id_t;
    typedef logic [CntW-1:0] cnt_t;

    // Slot table
    logic [1:0]  state_reg [NumTimers];
    logic [15:0] exp_reg   [NumTimers];
    logic [7:0]  prio_reg  [NumTimers];

    // Ordered list, ping-pong halves
    id_t  lst_reg [2][NumTimers];
    logic sel_reg;
    cnt_t n_reg, k_reg, m_reg;

    // Late slots to reinsert, last met on top
    id_t  stk_reg [NumTimers];
    cnt_t sp_reg;

    // Fired slots, sorted by priority descending
    id_t        fid_reg [NumTimers];
    logic [7:0] fpr_reg [NumTimers];
    cnt_t       fn_reg;

    // Captured item
    logic [2:0]  op_reg;
    id_t         tid_reg;
    logic        tid_ok_reg;
    logic [15:0] ticks_reg, now_reg;
    logic [7:0]  curp_reg, newp_reg;

    // Pass control
    logic        ins_reg, ins_done_reg, rem_reg, stop_reg;
    id_t         ins_id_reg;
    logic [15:0] x_exp_reg;

    // Result registers
    logic       strobe_reg, fired_reg, last_reg;
    logic [3:0] fired_id_reg;

    id_t         e, exp_addr;
    logic [15:0] exp_rd, edit_exp, walk_d;
    logic [7:0]  e_prio;
    logic        in_list, ins_hit;
    logic [NumTimers-1:0] c_vec, take_new, shift_in;

    // Read current list entry and its fields
    always_comb
    begin
        e            = lst_reg[sel_reg][k_reg[IdW-1:0]];
        exp_addr     = cmd.setup_edit ? tid_reg : e;
        exp_rd       = exp_reg[exp_addr];
        e_prio       = prio_reg[e];
        in_list      = k_reg < n_reg;
        ins_hit      = ins_reg && !ins_done_reg && not_later(x_exp_reg, exp_rd);
        walk_d       = now_reg - exp_rd;
        edit_exp     = ((op_reg == OP_SCHEDULE) ? now_reg : exp_rd) + ticks_reg;
    end

    // Insertion cells of the fired row
    always_comb
    begin
        for (int j = 0; j < NumTimers; j++)
        begin
            c_vec[j] = (cnt_t'(j) < fn_reg) && (e_prio >= fpr_reg[j]);
        end
        for (int j = 0; j < NumTimers; j++)
        begin
            take_new[j] = (cnt_t'(j) <= fn_reg)
                          && ((cnt_t'(j) == fn_reg) || c_vec[j])
                          && ((j == 0) || !c_vec[(j == 0) ? 0 : j - 1]);
            shift_in[j] = (j != 0) && c_vec[(j == 0) ? 0 : j - 1];
        end
    end

    always_comb
    begin
        sts.is_manage   = op_reg == OP_MANAGE;
        sts.edit_ok     = (op_reg <= OP_STOP) && tid_ok_reg;
        sts.pass_done   = !in_list && !(ins_reg && !ins_done_reg);
        sts.walk_done   = !in_list;
        sts.stk_empty   = sp_reg == '0;
        sts.fired_empty = fn_reg == '0;
        sts.fired_last  = fn_reg == cnt_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NumTimers; i++)
            begin
                state_reg[i] <= ST_STOPPED;
                exp_reg[i]   <= '0;
                prio_reg[i]  <= '0;
            end
            n_reg      <= '0;
            sel_reg    <= 1'b0;
            sp_reg     <= '0;
            fn_reg     <= '0;
            k_reg      <= '0;
            m_reg      <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            // Raise the strobe for one cycle per result
            strobe_reg <= cmd.emit || cmd.ack;

            // Capture the item
            if (cmd.load)
            begin
                op_reg     <= operation;
                tid_reg    <= id_t'(timer_id);
                tid_ok_reg <= int'(timer_id) < NumTimers;
                ticks_reg  <= ticks;
                now_reg    <= now;
                curp_reg   <= current_priority;
                newp_reg   <= new_priority;
                k_reg      <= '0;
                m_reg      <= '0;
                stop_reg   <= 1'b0;
                ins_reg    <= 1'b0;
                rem_reg    <= 1'b0;
            end

            // Update the addressed slot
            if (cmd.setup_edit)
            begin
                rem_reg      <= state_reg[tid_reg] == ST_SCHEDULED;
                ins_done_reg <= 1'b0;
                ins_id_reg   <= tid_reg;
                case (op_reg)
                    OP_INIT:
                    begin
                        state_reg[tid_reg] <= ST_STOPPED;
                        exp_reg[tid_reg]   <= '0;
                        prio_reg[tid_reg]  <= newp_reg;
                        ins_reg            <= 1'b0;
                    end
                    OP_SCHEDULE, OP_RESCHEDULE:
                    begin
                        state_reg[tid_reg] <= ST_SCHEDULED;
                        exp_reg[tid_reg]   <= edit_exp;
                        x_exp_reg          <= edit_exp;
                        ins_reg            <= 1'b1;
                    end
                    default:
                    begin
                        state_reg[tid_reg] <= ST_STOPPED;
                        ins_reg            <= 1'b0;
                    end
                endcase
            end

            // Copy the list, dropping and inserting one slot
            if (cmd.step_pass)
            begin
                if (in_list)
                begin
                    if (rem_reg && (e == tid_reg))
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                    else if (ins_hit)
                    begin
                        lst_reg[~sel_reg][m_reg[IdW-1:0]] <= ins_id_reg;
                        m_reg        <= m_reg + 1'b1;
                        ins_done_reg <= 1'b1;
                    end
                    else
                    begin
                        lst_reg[~sel_reg][m_reg[IdW-1:0]] <= e;
                        m_reg <= m_reg + 1'b1;
                        k_reg <= k_reg + 1'b1;
                    end
                end
                else if (ins_reg && !ins_done_reg)
                begin
                    lst_reg[~sel_reg][m_reg[IdW-1:0]] <= ins_id_reg;
                    m_reg        <= m_reg + 1'b1;
                    ins_done_reg <= 1'b1;
                end
                else
                begin
                    n_reg   <= m_reg;
                    sel_reg <= ~sel_reg;
                end
            end

            // Walk the list for manage
            if (cmd.step_walk)
            begin
                if (in_list)
                begin
                    k_reg <= k_reg + 1'b1;
                    if (stop_reg || walk_d[15])
                    begin
                        lst_reg[~sel_reg][m_reg[IdW-1:0]] <= e;
                        m_reg    <= m_reg + 1'b1;
                        stop_reg <= 1'b1;
                    end
                    else if (e_prio <= curp_reg)
                    begin
                        if (walk_d >= LATE_LIMIT)
                        begin
                            exp_reg[e]                  <= now_reg;
                            stk_reg[sp_reg[IdW-1:0]]    <= e;
                            sp_reg                      <= sp_reg + 1'b1;
                        end
                        else
                        begin
                            lst_reg[~sel_reg][m_reg[IdW-1:0]] <= e;
                            m_reg <= m_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        state_reg[e] <= ST_RUNNING;
                        fn_reg       <= fn_reg + 1'b1;
                        for (int j = 0; j < NumTimers; j++)
                        begin
                            if (take_new[j])
                            begin
                                fid_reg[j] <= e;
                                fpr_reg[j] <= e_prio;
                            end
                            else if (shift_in[j])
                            begin
                                fid_reg[j] <= fid_reg[(j == 0) ? 0 : j - 1];
                                fpr_reg[j] <= fpr_reg[(j == 0) ? 0 : j - 1];
                            end
                        end
                    end
                end
                else
                begin
                    n_reg   <= m_reg;
                    sel_reg <= ~sel_reg;
                end
            end

            // Pop one late slot for reinsertion
            if (cmd.setup_ins)
            begin
                ins_id_reg   <= stk_reg[IdW'(sp_reg - 1'b1)];
                sp_reg       <= sp_reg - 1'b1;
                x_exp_reg    <= now_reg;
                ins_reg      <= 1'b1;
                ins_done_reg <= 1'b0;
                rem_reg      <= 1'b0;
                k_reg        <= '0;
                m_reg        <= '0;
            end

            // Emit the head of the fired row
            if (cmd.emit)
            begin
                fired_reg    <= 1'b1;
                fired_id_reg <= 4'(fid_reg[0]);
                last_reg     <= fn_reg == cnt_t'(1);
                fn_reg       <= fn_reg - 1'b1;
                for (int j = 0; j < NumTimers - 1; j++)
                begin
                    fid_reg[j] <= fid_reg[j + 1];
                    fpr_reg[j] <= fpr_reg[j + 1];
                end
            end

            if (cmd.ack)
            begin
                fired_reg    <= 1'b0;
                fired_id_reg <= '0;
                last_reg     <= 1'b1;
            end
        end
    end

    assign strobe   = strobe_reg;
    assign fired    = fired_reg;
    assign fired_id = fired_id_reg;
    assign last     = last_reg;

    a_list_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= cnt_t'(NumTimers))
        else $error("list length beyond table size");

    a_ack_form: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !fired |-> last && (fired_id == 4'd0))
        else $error("acknowledgment malformed");

    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |=> !strobe)
        else $error("result after last");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> fn_reg != '0)
        else $error("emit from empty fired row");

endmodule

// ===== rtl/core/pts_ctrl.sv =====
module pts_ctrl import pts_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  pts_sts_t sts,
    output pts_cmd_t cmd
);

    ctl_state_t state_reg, state_next;
    ctl_state_t after_list;

    // Choose where to go once the list work of a manage is over
    always_comb
    begin
        if (!sts.stk_empty)
        begin
            after_list = S_INSSET;
        end
        else if (sts.fired_empty)
        begin
            after_list = S_ACK;
        end
        else
        begin
            after_list = S_EMIT;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (start) state_next = S_SETUP;
            S_SETUP:
                if (sts.is_manage)    state_next = S_WALK;
                else if (sts.edit_ok) state_next = S_PASS;
                else                  state_next = S_ACK;
            S_PASS:
                if (sts.pass_done) state_next = sts.is_manage ? after_list : S_ACK;
            S_WALK:
                if (sts.walk_done) state_next = after_list;
            S_INSSET:
                state_next = S_PASS;
            S_EMIT:
                if (sts.fired_last) state_next = S_IDLE;
            S_ACK:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd  = '0;
        busy = state_reg != S_IDLE;
        unique case (state_reg)
            S_IDLE:   cmd.load       = start;
            S_SETUP:  cmd.setup_edit = !sts.is_manage && sts.edit_ok;
            S_PASS:   cmd.step_pass  = 1'b1;
            S_WALK:   cmd.step_walk  = 1'b1;
            S_INSSET: cmd.setup_ins  = 1'b1;
            S_EMIT:   cmd.emit       = 1'b1;
            S_ACK:    cmd.ack        = 1'b1;
            default:  cmd            = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/priority_timer_scheduler_core.sv =====
// Timer table of NUM_TIMERS slots with priority-ordered firing.
// Command channel: an item is taken at a rising edge with start high and
// busy low; operation, timer_id, ticks, now, current_priority and
// new_priority are sampled then. busy drops in the cycle in which the
// item's last result sits on the result ports.
// Result channel: each result sits on fired_id, fired and last for one
// cycle with strobe high. Results cannot be held off by the receiver.
// Init, schedule, reschedule and stop give one acknowledgment after one
// list copy pass of one entry a cycle over the scheduled slots. Manage
// walks the list, then makes one pass for each slot pulled forward for
// being late, then emits the fired slots one per cycle, or an
// acknowledgment if none fired; fired slots come out highest priority
// first, ties with the later list entry first.
// Unknown operations and out-of-range slots are acknowledged without a pass.
// Reset leaves all slots stopped with zero expiry and priority, an empty
// list and no result pending.
module priority_timer_scheduler_core import pts_pkg::*; #(
    parameter int NUM_TIMERS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  operation,
    input  logic [3:0]  timer_id,
    input  logic [15:0] ticks,
    input  logic [15:0] now,
    input  logic [7:0]  current_priority,
    input  logic [7:0]  new_priority,
    output logic        strobe,
    output logic [3:0]  fired_id,
    output logic        fired,
    output logic        last
);

    pts_cmd_t cmd;
    pts_sts_t sts;

    pts_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    pts_dpath #(
        .NumTimers (NUM_TIMERS)
    ) u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .operation        (operation),
        .timer_id         (timer_id),
        .ticks            (ticks),
        .now              (now),
        .current_priority (current_priority),
        .new_priority     (new_priority),
        .strobe           (strobe),
        .fired_id         (fired_id),
        .fired            (fired),
        .last             (last)
    );

endmodule
